FILE: src/fnu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_pkg: shared types, widths and step functions for the face normal unit
// Fixed point widths of the unit-scaling pipeline and the digit steps of the
// pipelined square root and divider.
// ----------------------------------------------------------------------------
package fnu_pkg;

	localparam int COORD_W    = 32;              // corner coordinate, Q16.16
	localparam int EDGE_W     = COORD_W + 1;     // corner difference
	localparam int MAG_W      = 62;              // magnitude into a scaler
	localparam int LEN_W      = 6;               // bit length of a magnitude
	localparam int NORM_W     = 31;              // aligned magnitude
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int QUOT_W     = 31;
	localparam int DIV_W      = QUOT_W + NORM_W;
	localparam int COMP_W     = 32;              // signed scaled component
	localparam int PROD_W     = 2 * COMP_W;
	localparam int OUT_W      = 16;              // Q1.14 normal component
	localparam int EDGE_FRAC  = 30;
	localparam int NORM_FRAC  = 14;
	localparam int ONE_Q14    = 16384;

	// register stages of one scaler: align (5), root, divide set-up, divide, sign
	localparam int UNIT_LAT   = 5 + ROOT_W + 1 + QUOT_W + 1;
	// edge stages (2), cross product (3), output register (1)
	localparam int FNU_LAT    = 2 * UNIT_LAT + 6;

	typedef enum logic {
		UNIT_EDGE,
		UNIT_NORMAL
	} unit_mode_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} unit_stat_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_step_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic              qbit;
	} div_step_t;

	// one result bit of an integer square root
	function automatic root_step_t root_step(input logic [REM_W-1:0] rem,
			input logic [ROOT_W-1:0] root, input logic [1:0] pair);
		root_step_t       res;
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		r = {rem[REM_W-3:0], pair};
		t = {1'b0, root, 2'b01};
		if (r >= t) begin
			res.rem  = r - t;
			res.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			res.rem  = r;
			res.root = {root[ROOT_W-2:0], 1'b0};
		end
		return res;
	endfunction

	// one quotient bit of a restoring division
	function automatic div_step_t div_step(input logic [ROOT_W-1:0] rem,
			input logic bit_in, input logic [ROOT_W-1:0] len);
		div_step_t     res;
		logic [ROOT_W:0] r;
		logic [ROOT_W:0] d;
		r = {rem, bit_in};
		d = r - {1'b0, len};
		if (r >= {1'b0, len}) begin
			res.rem  = d[ROOT_W-1:0];
			res.qbit = 1'b1;
		end else begin
			res.rem  = r[ROOT_W-1:0];
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

FILE: src/fnu_unitize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_unitize: pipelined unit-vector scaler
// Aligns three magnitudes so the largest has 31 bits, takes the integer root
// of the sum of squares one bit per stage, then divides each component by it
// with rounding, one quotient bit per stage. mode is static per instance.
// ----------------------------------------------------------------------------
module fnu_unitize import fnu_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [2:0][MAG_W-1:0]        in_mag,
	input  logic [2:0]                   in_neg,
	input  unit_mode_t                   mode,
	output unit_stat_t                   out_stat,
	output logic [2:0][COMP_W-1:0]       out_comp
);

	// stage 1: largest magnitude
	logic                  v_s1;
	logic [2:0][MAG_W-1:0] mag_s1;
	logic [2:0]            neg_s1;
	logic [MAG_W-1:0]      top_s1;
	logic [MAG_W-1:0]      top_c;

	// stage 2: bit length of the largest
	logic                  v_s2;
	logic                  zero_s2;
	logic [2:0][MAG_W-1:0] mag_s2;
	logic [2:0]            neg_s2;
	logic [LEN_W-1:0]      n_s2;
	logic [LEN_W-1:0]      blen_c;

	// stage 3: aligned magnitudes
	logic                   v_s3;
	logic                   zero_s3;
	logic [2:0]             neg_s3;
	logic [2:0][NORM_W-1:0] m_s3;
	logic [2:0][NORM_W-1:0] m_c;

	// stage 4: squares
	logic                   v_s4;
	logic                   zero_s4;
	logic [2:0]             neg_s4;
	logic [2:0][NORM_W-1:0] m_s4;
	logic [2:0][SQ_W-1:0]   sq_s4;

	// stage 5: sum of squares
	logic                   v_s5;
	logic                   zero_s5;
	logic [2:0]             neg_s5;
	logic [2:0][NORM_W-1:0] m_s5;
	logic [SUM_W-1:0]       sum_s5;

	// root stages
	logic                   rt_v    [ROOT_W];
	logic                   rt_zero [ROOT_W];
	logic [2:0]             rt_neg  [ROOT_W];
	logic [2:0][NORM_W-1:0] rt_m    [ROOT_W];
	logic [SUM_W-1:0]       rt_x    [ROOT_W];
	logic [REM_W-1:0]       rt_rem  [ROOT_W];
	logic [ROOT_W-1:0]      rt_root [ROOT_W];
	logic [SUM_W-1:0]       rt_x_c    [ROOT_W];
	logic [REM_W-1:0]       rt_rem_c  [ROOT_W];
	logic [ROOT_W-1:0]      rt_root_c [ROOT_W];

	// divide set-up
	logic                   v_dp;
	logic                   zero_dp;
	logic [2:0]             neg_dp;
	logic [ROOT_W-1:0]      len_dp;
	logic [2:0][ROOT_W-1:0] rem_dp;
	logic [2:0][QUOT_W-1:0] low_dp;
	logic [ROOT_W-1:0]      len_c;
	logic [2:0][ROOT_W-1:0] rem0_c;
	logic [2:0][QUOT_W-1:0] low0_c;

	// divide stages
	logic                   dv_v    [QUOT_W];
	logic                   dv_zero [QUOT_W];
	logic [2:0]             dv_neg  [QUOT_W];
	logic [ROOT_W-1:0]      dv_len  [QUOT_W];
	logic [2:0][ROOT_W-1:0] dv_rem  [QUOT_W];
	logic [2:0][QUOT_W-1:0] dv_low  [QUOT_W];
	logic [2:0][QUOT_W-1:0] dv_q    [QUOT_W];
	logic [2:0][ROOT_W-1:0] dv_rem_c [QUOT_W];
	logic [2:0][QUOT_W-1:0] dv_low_c [QUOT_W];
	logic [2:0][QUOT_W-1:0] dv_q_c   [QUOT_W];

	// output
	logic                   v_q;
	logic                   zero_q;
	logic [2:0][COMP_W-1:0] comp_q;

	always_comb begin
		top_c = in_mag[0];
		if (in_mag[1] > top_c) top_c = in_mag[1];
		if (in_mag[2] > top_c) top_c = in_mag[2];
	end

	always_comb begin
		blen_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (top_s1[i]) blen_c = LEN_W'(i + 1);
		end
	end

	// magnitude * 2^31 >> n puts the leading one at bit 30, truncating
	always_comb begin
		logic [MAG_W+NORM_W-1:0] wide;
		for (int i = 0; i < 3; i++) begin
			wide   = {mag_s2[i], {NORM_W{1'b0}}} >> n_s2;
			m_c[i] = wide[NORM_W-1:0];
		end
	end

	always_comb begin
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SUM_W-1:0]  x_in;
		root_step_t        st;
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				rem_in  = '0;
				root_in = '0;
				x_in    = sum_s5;
			end else begin
				rem_in  = rt_rem[k-1];
				root_in = rt_root[k-1];
				x_in    = rt_x[k-1];
			end
			st           = root_step(rem_in, root_in, x_in[SUM_W-1 -: 2]);
			rt_rem_c[k]  = st.rem;
			rt_root_c[k] = st.root;
			rt_x_c[k]    = x_in << 2;
		end
	end

	// dividend = m * 2^F + len/2, so the quotient is rounded half up
	always_comb begin
		logic [DIV_W-1:0] d;
		len_c = rt_root[ROOT_W-1];
		for (int i = 0; i < 3; i++) begin
			if (mode == UNIT_EDGE) d = DIV_W'(rt_m[ROOT_W-1][i]) << EDGE_FRAC;
			else                   d = DIV_W'(rt_m[ROOT_W-1][i]) << NORM_FRAC;
			d         = d + DIV_W'(len_c >> 1);
			rem0_c[i] = ROOT_W'(d[DIV_W-1:QUOT_W]);
			low0_c[i] = d[QUOT_W-1:0];
		end
	end

	always_comb begin
		logic [ROOT_W-1:0]      len_in;
		logic [2:0][ROOT_W-1:0] rem_in;
		logic [2:0][QUOT_W-1:0] low_in;
		logic [2:0][QUOT_W-1:0] q_in;
		div_step_t              st;
		for (int j = 0; j < QUOT_W; j++) begin
			if (j == 0) begin
				len_in = len_dp;
				rem_in = rem_dp;
				low_in = low_dp;
				q_in   = '0;
			end else begin
				len_in = dv_len[j-1];
				rem_in = dv_rem[j-1];
				low_in = dv_low[j-1];
				q_in   = dv_q[j-1];
			end
			for (int i = 0; i < 3; i++) begin
				st             = div_step(rem_in[i], low_in[i][QUOT_W-1], len_in);
				dv_rem_c[j][i] = st.rem;
				dv_low_c[j][i] = low_in[i] << 1;
				dv_q_c[j][i]   = {q_in[i][QUOT_W-2:0], st.qbit};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_dp <= 1'b0;
			v_q  <= 1'b0;
			for (int k = 0; k < ROOT_W; k++) rt_v[k] <= 1'b0;
			for (int j = 0; j < QUOT_W; j++) dv_v[j] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			for (int k = 0; k < ROOT_W; k++) rt_v[k] <= (k == 0) ? v_s5 : rt_v[k-1];
			v_dp <= rt_v[ROOT_W-1];
			for (int j = 0; j < QUOT_W; j++) dv_v[j] <= (j == 0) ? v_dp : dv_v[j-1];
			v_q  <= dv_v[QUOT_W-1];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		mag_s1  <= in_mag;
		neg_s1  <= in_neg;
		top_s1  <= top_c;

		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		n_s2    <= blen_c;
		zero_s2 <= (top_s1 == '0);

		m_s3    <= m_c;
		neg_s3  <= neg_s2;
		zero_s3 <= zero_s2;

		m_s4    <= m_s3;
		neg_s4  <= neg_s3;
		zero_s4 <= zero_s3;
		for (int i = 0; i < 3; i++) sq_s4[i] <= SQ_W'(m_s3[i]) * SQ_W'(m_s3[i]);

		m_s5    <= m_s4;
		neg_s5  <= neg_s4;
		zero_s5 <= zero_s4;
		sum_s5  <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);

		for (int k = 0; k < ROOT_W; k++) begin
			rt_rem[k]  <= rt_rem_c[k];
			rt_root[k] <= rt_root_c[k];
			rt_x[k]    <= rt_x_c[k];
			if (k == 0) begin
				rt_m[k]    <= m_s5;
				rt_neg[k]  <= neg_s5;
				rt_zero[k] <= zero_s5;
			end else begin
				rt_m[k]    <= rt_m[k-1];
				rt_neg[k]  <= rt_neg[k-1];
				rt_zero[k] <= rt_zero[k-1];
			end
		end

		len_dp  <= len_c;
		rem_dp  <= rem0_c;
		low_dp  <= low0_c;
		neg_dp  <= rt_neg[ROOT_W-1];
		zero_dp <= rt_zero[ROOT_W-1];

		for (int j = 0; j < QUOT_W; j++) begin
			dv_rem[j] <= dv_rem_c[j];
			dv_low[j] <= dv_low_c[j];
			dv_q[j]   <= dv_q_c[j];
			if (j == 0) begin
				dv_len[j]  <= len_dp;
				dv_neg[j]  <= neg_dp;
				dv_zero[j] <= zero_dp;
			end else begin
				dv_len[j]  <= dv_len[j-1];
				dv_neg[j]  <= dv_neg[j-1];
				dv_zero[j] <= dv_zero[j-1];
			end
		end

		zero_q <= dv_zero[QUOT_W-1];
		for (int i = 0; i < 3; i++) begin
			if (dv_neg[QUOT_W-1][i]) comp_q[i] <= COMP_W'(0) - COMP_W'(dv_q[QUOT_W-1][i]);
			else                     comp_q[i] <= COMP_W'(dv_q[QUOT_W-1][i]);
		end
	end

	assign out_stat.valid = v_q;
	assign out_stat.zero  = zero_q;
	assign out_comp       = comp_q;

endmodule

FILE: src/face_normal_unit_top.sv
`timescale 1ns / 1ps
// A face taken at a clock edge passes through two scaler pipelines of 70
// stages each, every root and quotient bit a stage, before its done strobe.
// Throughput: one face per cycle; busy is always low and nothing back-pressures.
// Reset clears every valid bit at once; data registers are not reset.
// ----------------------------------------------------------------------------
// face_normal_unit_top: unit normal of a triangle face
// Edges A-B and A-C are scaled to unit length, crossed, and the cross
// product scaled to a Q1.14 unit normal. A zero edge or cross product gives
// a zero normal with degenerate set.
// ----------------------------------------------------------------------------
module face_normal_unit_top import fnu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] corner_a_x,
	input  logic signed [COORD_W-1:0] corner_a_y,
	input  logic signed [COORD_W-1:0] corner_a_z,
	input  logic signed [COORD_W-1:0] corner_b_x,
	input  logic signed [COORD_W-1:0] corner_b_y,
	input  logic signed [COORD_W-1:0] corner_b_z,
	input  logic signed [COORD_W-1:0] corner_c_x,
	input  logic signed [COORD_W-1:0] corner_c_y,
	input  logic signed [COORD_W-1:0] corner_c_z,
	output logic                      done,
	output logic signed [OUT_W-1:0]   normal_x,
	output logic signed [OUT_W-1:0]   normal_y,
	output logic signed [OUT_W-1:0]   normal_z,
	output logic                      degenerate
);

	logic [2:0][COORD_W-1:0] a_c, b_c, c_c;

	logic                    v_t1;
	logic [2:0][EDGE_W-1:0]  e1_t1, e2_t1;

	logic                    v_t2;
	logic [2:0][MAG_W-1:0]   mag1_t2, mag2_t2;
	logic [2:0]              neg1_t2, neg2_t2;

	unit_stat_t              stat_a, stat_b, stat_c;
	logic [2:0][COMP_W-1:0]  u1, u2, nv;

	logic                    v_t3;
	logic signed [PROD_W-1:0] p_t3 [6];
	logic signed [PROD_W-1:0] p_c  [6];

	logic                    v_t4;
	logic [2:0][PROD_W-1:0]  cr_t4;

	logic                    v_t5;
	logic [2:0][MAG_W-1:0]   mag_t5;
	logic [2:0]              neg_t5;

	logic                    done_q;
	logic                    deg_q;
	logic [2:0][OUT_W-1:0]   nrm_q;

	function automatic logic [OUT_W-1:0] clamp_q14(input logic [COMP_W-1:0] v);
		logic signed [COMP_W-1:0] s;
		s = $signed(v);
		if (s > ONE_Q14)       return OUT_W'(ONE_Q14);
		else if (s < -ONE_Q14) return OUT_W'(-ONE_Q14);
		else                   return s[OUT_W-1:0];
	endfunction

	assign busy = 1'b0;

	assign a_c = {corner_a_z, corner_a_y, corner_a_x};
	assign b_c = {corner_b_z, corner_b_y, corner_b_x};
	assign c_c = {corner_c_z, corner_c_y, corner_c_x};

	always_comb begin
		p_c[0] = $signed(u1[1]) * $signed(u2[2]);
		p_c[1] = $signed(u1[2]) * $signed(u2[1]);
		p_c[2] = $signed(u1[2]) * $signed(u2[0]);
		p_c[3] = $signed(u1[0]) * $signed(u2[2]);
		p_c[4] = $signed(u1[0]) * $signed(u2[1]);
		p_c[5] = $signed(u1[1]) * $signed(u2[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1   <= 1'b0;
			v_t2   <= 1'b0;
			v_t3   <= 1'b0;
			v_t4   <= 1'b0;
			v_t5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_t1   <= start;
			v_t2   <= v_t1;
			v_t3   <= stat_a.valid;
			v_t4   <= v_t3;
			v_t5   <= v_t4;
			done_q <= stat_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [EDGE_W-1:0] abs1, abs2;
		logic [PROD_W-1:0] abs_cr;
		for (int i = 0; i < 3; i++) begin
			e1_t1[i] <= {a_c[i][COORD_W-1], a_c[i]} - {b_c[i][COORD_W-1], b_c[i]};
			e2_t1[i] <= {a_c[i][COORD_W-1], a_c[i]} - {c_c[i][COORD_W-1], c_c[i]};

			abs1 = e1_t1[i][EDGE_W-1] ? EDGE_W'(0) - e1_t1[i] : e1_t1[i];
			abs2 = e2_t1[i][EDGE_W-1] ? EDGE_W'(0) - e2_t1[i] : e2_t1[i];
			mag1_t2[i] <= MAG_W'(abs1);
			mag2_t2[i] <= MAG_W'(abs2);
			neg1_t2[i] <= e1_t1[i][EDGE_W-1];
			neg2_t2[i] <= e2_t1[i][EDGE_W-1];
		end

		// a zero edge forces a zero cross product, which the last scaler flags
		for (int k = 0; k < 6; k++) begin
			p_t3[k] <= (stat_a.zero || stat_b.zero) ? '0 : p_c[k];
		end

		cr_t4[0] <= p_t3[0] - p_t3[1];
		cr_t4[1] <= p_t3[2] - p_t3[3];
		cr_t4[2] <= p_t3[4] - p_t3[5];

		for (int i = 0; i < 3; i++) begin
			abs_cr    = cr_t4[i][PROD_W-1] ? PROD_W'(0) - cr_t4[i] : cr_t4[i];
			mag_t5[i] <= abs_cr[MAG_W-1:0];
			neg_t5[i] <= cr_t4[i][PROD_W-1];
		end

		deg_q <= stat_c.zero;
		for (int i = 0; i < 3; i++) begin
			nrm_q[i] <= stat_c.zero ? '0 : clamp_q14(nv[i]);
		end
	end

	fnu_unitize u_edge1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_t2),
		.in_mag   (mag1_t2),
		.in_neg   (neg1_t2),
		.mode     (UNIT_EDGE),
		.out_stat (stat_a),
		.out_comp (u1)
	);

	fnu_unitize u_edge2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_t2),
		.in_mag   (mag2_t2),
		.in_neg   (neg2_t2),
		.mode     (UNIT_EDGE),
		.out_stat (stat_b),
		.out_comp (u2)
	);

	fnu_unitize u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_t5),
		.in_mag   (mag_t5),
		.in_neg   (neg_t5),
		.mode     (UNIT_NORMAL),
		.out_stat (stat_c),
		.out_comp (nv)
	);

	assign done       = done_q;
	assign degenerate = deg_q;
	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];

endmodule

FILE: src/fnu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_checker: port-level checks on the face normal unit
// Fixed latency, no spurious results, zero normal on degenerate faces and
// components within one.
// ----------------------------------------------------------------------------
module fnu_checker import fnu_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [OUT_W-1:0]   normal_x,
	input logic signed [OUT_W-1:0]   normal_y,
	input logic signed [OUT_W-1:0]   normal_z,
	input logic                      degenerate
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##FNU_LAT done)
		else $error("transaction result missing at fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, FNU_LAT))
		else $error("result without a transaction");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
		else $error("degenerate face with non-zero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= ONE_Q14 && normal_x >= -ONE_Q14 &&
		          normal_y <= ONE_Q14 && normal_y >= -ONE_Q14 &&
		          normal_z <= ONE_Q14 && normal_z >= -ONE_Q14))
		else $error("normal component beyond one");

endmodule

bind face_normal_unit_top fnu_checker u_fnu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);

FILE: sim/face_normal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_normal_checker: predictor and scoreboard for the face normal unit
// Captures every face accepted on the command side, computes its unit normal
// and degenerate flag, and compares each done strobe with the oldest
// outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module face_normal_checker import fnu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [COORD_W-1:0] corner_a_x,
	input  logic signed [COORD_W-1:0] corner_a_y,
	input  logic signed [COORD_W-1:0] corner_a_z,
	input  logic signed [COORD_W-1:0] corner_b_x,
	input  logic signed [COORD_W-1:0] corner_b_y,
	input  logic signed [COORD_W-1:0] corner_b_z,
	input  logic signed [COORD_W-1:0] corner_c_x,
	input  logic signed [COORD_W-1:0] corner_c_y,
	input  logic signed [COORD_W-1:0] corner_c_z,
	input  logic                      done,
	input  logic signed [OUT_W-1:0]   normal_x,
	input  logic signed [OUT_W-1:0]   normal_y,
	input  logic signed [OUT_W-1:0]   normal_z,
	input  logic                      degenerate,
	output int                        fail_count,
	output int                        pending,
	output int                        face_count,
	output int                        degenerate_count
);

	typedef logic [2:0][63:0] vec_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] nx;
		logic signed [OUT_W-1:0] ny;
		logic signed [OUT_W-1:0] nz;
		logic                    degen;
	} normal_t;

	normal_t normal_q[$];

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x   = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// scale to unit length with frac fraction bits; returns 0 for a zero vector
	function automatic bit unit_scale(input vec_t v, input int frac, output vec_t u);
		logic [63:0] m[3];
		bit          neg[3];
		logic [63:0] top, sum, len, q;
		int          n;
		top = 0;
		sum = 0;
		u   = '0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = $signed(v[i]) < 0;
			m[i]   = neg[i] ? -v[i] : v[i];
			if (m[i] > top)
				top = m[i];
		end
		if (top == 0)
			return 0;
		n = 0;
		while (top != 0) begin
			n++;
			top >>= 1;
		end
		for (int i = 0; i < 3; i++) begin
			if (n > 31)
				m[i] >>= (n - 31);
			else
				m[i] <<= (31 - n);
			sum += m[i] * m[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q    = ((m[i] << frac) + (len >> 1)) / len;
			u[i] = neg[i] ? -q : q;
		end
		return 1;
	endfunction

	function automatic normal_t face_normal(input vec_t a, input vec_t b, input vec_t c);
		vec_t    e1, e2, u1, u2, cr, nv;
		normal_t r;
		logic signed [63:0] s;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			e1[i] = $signed(a[i]) - $signed(b[i]);
			e2[i] = $signed(a[i]) - $signed(c[i]);
		end
		if (!unit_scale(e1, EDGE_FRAC, u1) || !unit_scale(e2, EDGE_FRAC, u2)) begin
			r.degen = 1'b1;
			return r;
		end
		cr[0] = $signed(u1[1]) * $signed(u2[2]) - $signed(u1[2]) * $signed(u2[1]);
		cr[1] = $signed(u1[2]) * $signed(u2[0]) - $signed(u1[0]) * $signed(u2[2]);
		cr[2] = $signed(u1[0]) * $signed(u2[1]) - $signed(u1[1]) * $signed(u2[0]);
		if (!unit_scale(cr, NORM_FRAC, nv)) begin
			r.degen = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			s = $signed(nv[i]);
			if (s > ONE_Q14)
				s = ONE_Q14;
			if (s < -ONE_Q14)
				s = -ONE_Q14;
			nv[i] = s;
		end
		r.nx = nv[0][OUT_W-1:0];
		r.ny = nv[1][OUT_W-1:0];
		r.nz = nv[2][OUT_W-1:0];
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count       = 0;
		face_count       = 0;
		degenerate_count = 0;
	end

	assign pending = normal_q.size();

	always @(posedge clk) begin
		normal_t want;
		vec_t    a, b, c;
		if (arst_n) begin
			if (done) begin
				if (normal_q.size() == 0) begin
					$display("[%0t] done strobe with no face outstanding", $time);
					fail_count++;
				end else begin
					want = normal_q.pop_front();
					if (normal_x !== want.nx)
						report("normal_x", normal_x, want.nx);
					if (normal_y !== want.ny)
						report("normal_y", normal_y, want.ny);
					if (normal_z !== want.nz)
						report("normal_z", normal_z, want.nz);
					if (degenerate !== want.degen)
						report("degenerate", degenerate, want.degen);
				end
			end
			if (start && !busy) begin
				a = {64'(corner_a_z), 64'(corner_a_y), 64'(corner_a_x)};
				b = {64'(corner_b_z), 64'(corner_b_y), 64'(corner_b_x)};
				c = {64'(corner_c_z), 64'(corner_c_y), 64'(corner_c_x)};
				want = face_normal(a, b, c);
				normal_q.push_back(want);
				face_count++;
				if (want.degen)
					degenerate_count++;
			end
		end
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for face_normal_unit_top
// Drives directed and random faces with random gaps between transactions and
// gap-free bursts; the checker predicts every normal and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import fnu_pkg::*;

	localparam int RANDOM_FACES = 1100;
	localparam int IDLE_LIMIT   = 2000;

	typedef logic [8:0][COORD_W-1:0] face_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, degenerate;
	logic signed [COORD_W-1:0] corner[9] = '{default: '0};
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
	int fail_count, pending, face_count, degenerate_count;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	face_normal_unit_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner_a_x(corner[0]), .corner_a_y(corner[1]), .corner_a_z(corner[2]),
		.corner_b_x(corner[3]), .corner_b_y(corner[4]), .corner_b_z(corner[5]),
		.corner_c_x(corner[6]), .corner_c_y(corner[7]), .corner_c_z(corner[8]),
		.done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	face_normal_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner_a_x(corner[0]), .corner_a_y(corner[1]), .corner_a_z(corner[2]),
		.corner_b_x(corner[3]), .corner_b_y(corner[4]), .corner_b_z(corner[5]),
		.corner_c_x(corner[6]), .corner_c_y(corner[7]), .corner_c_z(corner[8]),
		.done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate), .fail_count(fail_count), .pending(pending),
		.face_count(face_count), .degenerate_count(degenerate_count)
	);

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d normals outstanding", pending);
			$display("face_normal_unit_top test failed");
			$finish;
		end
	end

	task automatic send_face(input face_t f);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		for (int i = 0; i < 9; i++)
			corner[i] <= f[i];
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] small_coord(input int span);
		return COORD_W'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic face_t random_face();
		face_t f;
		int    k1, k2;
		logic signed [COORD_W-1:0] d;
		case ($urandom_range(0, 3))
			0: for (int i = 0; i < 9; i++)
				f[i] = $urandom;
			1: for (int i = 0; i < 9; i++)
				f[i] = small_coord(3);
			2: for (int i = 0; i < 9; i++)
				f[i] = small_coord(1 << 20);
			default: begin
				// collinear corners, optionally nudged off the line
				k1 = $urandom_range(1, 7) * ($urandom_range(0, 1) ? 1 : -1);
				k2 = $urandom_range(1, 7) * ($urandom_range(0, 1) ? 1 : -1);
				for (int i = 0; i < 3; i++) begin
					f[i]     = small_coord(1 << 24);
					d        = small_coord(1 << 16);
					f[3 + i] = f[i] - d * k1;
					f[6 + i] = f[i] - d * k2;
				end
				if ($urandom_range(0, 2) == 0)
					f[6 + $urandom_range(0, 2)] += 1;
			end
		endcase
		return f;
	endfunction

	initial begin
		face_t f;
		logic [COORD_W-1:0] hi, lo;
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit right triangles in the XY plane, both orientations, and in the XZ plane
		send_face({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0});
		send_face({32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0});
		send_face({32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0});
		// zero edge A-B, then zero edge A-C
		send_face({32'h3, 32'h2, 32'h1, 32'h7, 32'h8, 32'h9, 32'h7, 32'h8, 32'h9});
		send_face({32'h7, 32'h8, 32'h9, 32'h3, 32'h2, 32'h1, 32'h7, 32'h8, 32'h9});
		// all corners equal
		send_face({9{32'h12345678}});
		// parallel edges, same and opposite direction
		send_face({32'h3, 32'h3, 32'h3, 32'h2, 32'h2, 32'h2, 32'h1, 32'h1, 32'h1});
		send_face({32'h5, 32'h5, 32'h5, 32'h1, 32'h1, 32'h1, 32'h3, 32'h3, 32'h3});
		// coordinate extremes, widest possible edges
		send_face({lo, lo, lo, hi, hi, lo, hi, lo, hi});
		send_face({hi, hi, hi, lo, lo, hi, lo, hi, lo});
		send_face({lo, hi, lo, hi, lo, hi, lo, lo, hi});
		send_face({lo, lo, hi, lo, hi, lo, hi, lo, lo});
		send_face({hi, lo, lo, lo, hi, lo, lo, lo, hi});
		send_face({32'hFFFFFFFF, 32'h0, 32'h1, 32'h1, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h1,
			32'hFFFFFFFF});
		// nearly parallel edges with a tiny cross product, then a long edge beside a short one
		send_face({32'h0, 32'h1, 32'h40000000, 32'h0, 32'h0, 32'h20000000, 32'h0, 32'h0,
			32'h0});
		send_face({32'h0, 32'h0, hi, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0});

		for (int n = 0; n < RANDOM_FACES; n++) begin
			if ($urandom_range(0, 15) == 0) begin
				// a burst with no gaps
				repeat ($urandom_range(5, 20)) begin
					f = random_face();
					for (int i = 0; i < 9; i++)
						corner[i] <= f[i];
					start <= 1'b1;
					@(posedge clk);
					while (busy)
						@(posedge clk);
					n++;
				end
			end else begin
				send_face(random_face());
			end
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (FNU_LAT + 10) @(posedge clk);

		$display("%0d faces checked, %0d of them degenerate", face_count, degenerate_count);
		$display("mix of axis-aligned, extreme, collinear and random faces; %0d mismatches",
			fail_count);
		if (fail_count == 0 && pending == 0)
			$display("face_normal_unit_top test passed");
		else
			$display("face_normal_unit_top test failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/fnu_pkg.sv
src/fnu_unitize.sv
src/face_normal_unit_top.sv
src/fnu_checker.sv
sim/face_normal_checker.sv
sim/tb_top.sv
